// File: rtl/ouart_pkg.sv
`timescale 1ns / 1ps

package ouart_pkg;

    localparam int OVERSAMPLE_DEF = 5;
    localparam int RX_DEPTH_DEF   = 16;
    localparam int TX_DEPTH_DEF   = 16;

    localparam int START_DELAY    = 2;

    localparam logic [3:0] RX_STOP_BIT = 4'd9;
    localparam logic [3:0] TX_STOP_BIT = 4'd9;
    localparam logic [3:0] TX_GAP_BIT  = 4'd10;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_RX_ENABLE = 1'b0;

    typedef struct packed {
        logic [4:0] pad;
        logic       rx_pop;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       rx_level;
    } tick_word_t;

    typedef struct packed {
        logic       pad;
        logic [3:0] rx_count;
        logic [7:0] rx_head_byte;
        logic       tx_ready;
        logic       tx_busy;
        logic       tx_level;
    } status_word_t;

endpackage

// File: rtl/oversampled_uart_8n1_unit.sv
`timescale 1ns / 1ps

// Each accepted tick word's status word is computed combinationally and registered in the output register.
// Throughput: one tick word per cycle; a new word is taken whenever the output register
// is empty or is being drained in the same cycle.
// Reset (rst_n low, asynchronous): counters, fill levels and flags clear, the transmit
// line goes idle high and receive is disabled. FIFO contents are not cleared.
module oversampled_uart_8n1_unit
    import ouart_pkg::*;
#(
    parameter int OVERSAMPLE = OVERSAMPLE_DEF,
    parameter int RX_DEPTH   = RX_DEPTH_DEF,
    parameter int TX_DEPTH   = TX_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: rx_level, tx_valid, tx_byte[7:0], rx_pop, zero padding.
    input  logic [IN_DATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: tx_level, tx_busy, tx_ready, rx_head_byte[7:0], rx_count[3:0],
    // zero padding.
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW  = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam int RFW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TFW = $clog2(TX_DEPTH + 1);

    logic              rx_enable_reg;
    logic [PW-1:0]     tick_phase_reg,      tick_phase_next;
    logic              rx_locked_reg,       rx_locked_next;
    logic [PW-1:0]     rx_sample_phase_reg, rx_sample_phase_next;
    logic [3:0]        rx_bit_count_reg,    rx_bit_count_next;
    logic [7:0]        rx_shift_reg,        rx_shift_next;
    logic [RFW-1:0]    rx_fill_reg,         rx_fill_next;
    logic [TFW-1:0]    tx_fill_reg,         tx_fill_next;
    logic [3:0]        tx_bit_count_reg,    tx_bit_count_next;
    logic              tx_active_reg,       tx_active_next;
    logic              tx_line_reg,         tx_line_next;
    logic [7:0]        rx_store_reg [RX_DEPTH];
    logic [7:0]        rx_store_next [RX_DEPTH];
    logic [7:0]        tx_store_reg [TX_DEPTH];
    logic [7:0]        tx_store_next [TX_DEPTH];

    logic              m_tvalid_reg;
    status_word_t      m_word_reg, m_word_next;

    tick_word_t        in_word;
    logic              accept;
    logic              cfg_write;

    logic              pop_ok;
    logic              push_ok;
    logic [RFW-1:0]    rx_fill_pop;
    logic [TFW-1:0]    tx_fill_push;
    logic              rx_write;
    logic              tx_shift;
    logic [PW:0]       phase_sum;
    logic [3:0]        rx_cnt_m1;
    logic [3:0]        tx_cnt_m1;
    logic [7:0]        tx_head;
    logic [7:0]        rx_mid [RX_DEPTH];
    logic [7:0]        tx_mid [TX_DEPTH];
    logic [RFW+3:0]    rx_fill_ext;

    assign in_word   = tick_word_t'(s_tdata);
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_DATA_W'(m_word_reg);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_RX_ENABLE) ? {{(APB_DATA_W-1){1'b0}}, rx_enable_reg}
                                                   : '0;

    always_comb
    begin
        pop_ok       = in_word.rx_pop && (rx_fill_reg != '0);
        rx_fill_pop  = rx_fill_reg - RFW'(pop_ok);
        push_ok      = in_word.tx_valid && (tx_fill_reg < TFW'(TX_DEPTH));
        tx_fill_push = tx_fill_reg + TFW'(push_ok);

        tx_active_next    = tx_active_reg;
        tx_bit_count_next = tx_bit_count_reg;
        if (push_ok && !tx_active_reg)
        begin
            tx_active_next    = 1'b1;
            tx_bit_count_next = 4'd0;
        end

        rx_locked_next       = rx_locked_reg;
        rx_sample_phase_next = rx_sample_phase_reg;
        phase_sum            = {1'b0, tick_phase_reg} + (PW+1)'(START_DELAY);
        if (phase_sum >= (PW+1)'(OVERSAMPLE))
        begin
            phase_sum = phase_sum - (PW+1)'(OVERSAMPLE);
        end
        if (rx_enable_reg && (rx_bit_count_reg == 4'd0) && !rx_locked_reg && !in_word.rx_level)
        begin
            rx_sample_phase_next = phase_sum[PW-1:0];
            rx_locked_next       = 1'b1;
        end

        rx_bit_count_next = rx_bit_count_reg;
        rx_shift_next     = rx_shift_reg;
        rx_write          = 1'b0;
        rx_cnt_m1         = rx_bit_count_reg - 4'd1;
        if (rx_enable_reg && (rx_sample_phase_next == tick_phase_reg))
        begin
            if (rx_bit_count_reg == 4'd0)
            begin
                if (!in_word.rx_level)
                begin
                    rx_shift_next     = 8'd0;
                    rx_bit_count_next = 4'd1;
                end
            end
            else if (rx_bit_count_reg < RX_STOP_BIT)
            begin
                rx_shift_next[rx_cnt_m1[2:0]] = rx_shift_reg[rx_cnt_m1[2:0]] | in_word.rx_level;
                rx_bit_count_next = rx_bit_count_reg + 4'd1;
            end
            else
            begin
                rx_bit_count_next = 4'd0;
                rx_locked_next    = 1'b0;
                rx_write = in_word.rx_level && (rx_fill_pop < RFW'(RX_DEPTH - 1));
            end
        end
        rx_fill_next = rx_fill_pop + RFW'(rx_write);

        for (int i = 0; i < RX_DEPTH - 1; i++)
        begin
            rx_mid[i] = pop_ok ? rx_store_reg[i+1] : rx_store_reg[i];
        end
        rx_mid[RX_DEPTH-1] = rx_store_reg[RX_DEPTH-1];
        for (int i = 0; i < RX_DEPTH; i++)
        begin
            rx_store_next[i] = (rx_write && (rx_fill_pop == RFW'(i))) ? rx_shift_reg : rx_mid[i];
        end

        for (int i = 0; i < TX_DEPTH; i++)
        begin
            tx_mid[i] = (push_ok && (tx_fill_reg == TFW'(i))) ? in_word.tx_byte
                                                              : tx_store_reg[i];
        end
        tx_head      = tx_mid[0];
        tx_line_next = tx_line_reg;
        tx_fill_next = tx_fill_push;
        tx_shift     = 1'b0;
        tx_cnt_m1    = tx_bit_count_next - 4'd1;
        if ((tick_phase_reg == '0) && tx_active_next)
        begin
            if (tx_bit_count_next == 4'd0)
            begin
                tx_line_next      = 1'b0;
                tx_bit_count_next = 4'd1;
            end
            else if (tx_bit_count_next < TX_STOP_BIT)
            begin
                tx_line_next      = tx_head[tx_cnt_m1[2:0]];
                tx_bit_count_next = tx_bit_count_next + 4'd1;
            end
            else if (tx_bit_count_next == TX_STOP_BIT)
            begin
                tx_line_next      = 1'b1;
                tx_bit_count_next = TX_GAP_BIT;
            end
            else
            begin
                tx_bit_count_next = 4'd0;
                tx_shift          = (tx_fill_push != '0);
                tx_fill_next      = tx_fill_push - TFW'(tx_shift);
                tx_active_next    = (tx_fill_next != '0);
            end
        end

        for (int i = 0; i < TX_DEPTH - 1; i++)
        begin
            tx_store_next[i] = tx_shift ? tx_mid[i+1] : tx_mid[i];
        end
        tx_store_next[TX_DEPTH-1] = tx_mid[TX_DEPTH-1];

        if (tick_phase_reg == PW'(OVERSAMPLE - 1))
        begin
            tick_phase_next = '0;
        end
        else
        begin
            tick_phase_next = tick_phase_reg + PW'(1);
        end

        rx_fill_ext               = {4'd0, rx_fill_next};
        m_word_next.pad           = 1'b0;
        m_word_next.rx_count      = rx_fill_ext[3:0];
        m_word_next.rx_head_byte  = (rx_fill_next != '0) ? rx_store_next[0] : 8'd0;
        m_word_next.tx_ready      = (tx_fill_next < TFW'(TX_DEPTH));
        m_word_next.tx_busy       = tx_active_next || (tx_fill_next != '0);
        m_word_next.tx_level      = tx_line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enable_reg       <= 1'b0;
            tick_phase_reg      <= '0;
            rx_locked_reg       <= 1'b0;
            rx_sample_phase_reg <= '0;
            rx_bit_count_reg    <= 4'd0;
            rx_shift_reg        <= 8'd0;
            rx_fill_reg         <= '0;
            tx_fill_reg         <= '0;
            tx_bit_count_reg    <= 4'd0;
            tx_active_reg       <= 1'b0;
            tx_line_reg         <= 1'b1;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_RX_ENABLE))
            begin
                rx_enable_reg <= pwdata[0];
            end
            if (accept)
            begin
                tick_phase_reg      <= tick_phase_next;
                rx_locked_reg       <= rx_locked_next;
                rx_sample_phase_reg <= rx_sample_phase_next;
                rx_bit_count_reg    <= rx_bit_count_next;
                rx_shift_reg        <= rx_shift_next;
                rx_fill_reg         <= rx_fill_next;
                tx_fill_reg         <= tx_fill_next;
                tx_bit_count_reg    <= tx_bit_count_next;
                tx_active_reg       <= tx_active_next;
                tx_line_reg         <= tx_line_next;
                m_tvalid_reg        <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_word_reg <= m_word_next;
            for (int i = 0; i < RX_DEPTH; i++)
            begin
                rx_store_reg[i] <= rx_store_next[i];
            end
            for (int i = 0; i < TX_DEPTH; i++)
            begin
                tx_store_reg[i] <= tx_store_next[i];
            end
        end
    end

endmodule

// File: verif/tb_oversampled_uart_8n1_unit.sv
`timescale 1ns / 1ps

module tb_oversampled_uart_8n1_unit;

    import ouart_pkg::*;

    localparam logic [APB_ADDR_W-1:0] RX_ENABLE_ADDR = APB_ADDR_W'(4 * REG_RX_ENABLE);

    class uart_scoreboard;
        logic       rx_on;
        logic [2:0] phase;
        logic       rx_phase_held;
        logic [2:0] rx_pick;
        logic [3:0] rx_bit_idx;
        logic [7:0] rx_shreg;
        logic [7:0] rx_fifo [RX_DEPTH_DEF];
        logic [4:0] rx_used;
        logic [7:0] tx_fifo [TX_DEPTH_DEF];
        logic [4:0] tx_used;
        logic [3:0] tx_slot;
        logic       tx_running;
        logic       tx_pin;
        status_word_t status_due [$];
        int errors;

        function new();
            rx_on         = 1'b0;
            phase         = '0;
            rx_phase_held = 1'b0;
            rx_pick       = '0;
            rx_bit_idx    = '0;
            rx_shreg      = '0;
            rx_used       = '0;
            tx_used       = '0;
            tx_slot       = '0;
            tx_running    = 1'b0;
            tx_pin        = 1'b1;
            errors        = 0;
        endfunction

        function void set_rx_on(logic value);
            rx_on = value;
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function void take_rx_bit(logic level);
            if (rx_bit_idx == 4'd0) begin
                if (!level) begin
                    rx_shreg   = '0;
                    rx_bit_idx = 4'd1;
                end
            end else if (rx_bit_idx < RX_STOP_BIT) begin
                rx_shreg[3'(rx_bit_idx - 4'd1)] = level;
                rx_bit_idx = rx_bit_idx + 4'd1;
            end else begin
                rx_bit_idx    = '0;
                rx_phase_held = 1'b0;
                if (level && rx_used < RX_DEPTH_DEF - 1) begin
                    rx_fifo[rx_used[3:0]] = rx_shreg;
                    rx_used = rx_used + 5'd1;
                end
            end
        endfunction

        function void drive_tx_slot();
            if (tx_running) begin
                if (tx_slot == 4'd0) begin
                    tx_pin  = 1'b0;
                    tx_slot = 4'd1;
                end else if (tx_slot < TX_STOP_BIT) begin
                    tx_pin  = tx_fifo[0][3'(tx_slot - 4'd1)];
                    tx_slot = tx_slot + 4'd1;
                end else if (tx_slot == TX_STOP_BIT) begin
                    tx_pin  = 1'b1;
                    tx_slot = TX_GAP_BIT;
                end else begin
                    tx_slot = '0;
                    if (tx_used > 0) begin
                        for (int i = 0; i < TX_DEPTH_DEF - 1; i++)
                            tx_fifo[i] = tx_fifo[i + 1];
                        tx_used = tx_used - 5'd1;
                    end
                    tx_running = (tx_used > 0);
                end
            end
        endfunction

        function void note_tick(tick_word_t t);
            status_word_t s;
            if (t.rx_pop && rx_used > 0) begin
                for (int i = 0; i < RX_DEPTH_DEF - 1; i++)
                    rx_fifo[i] = rx_fifo[i + 1];
                rx_used = rx_used - 5'd1;
            end
            if (t.tx_valid && tx_used < TX_DEPTH_DEF) begin
                tx_fifo[tx_used[3:0]] = t.tx_byte;
                tx_used = tx_used + 5'd1;
                if (!tx_running) begin
                    tx_running = 1'b1;
                    tx_slot    = '0;
                end
            end
            if (rx_on && rx_bit_idx == 4'd0 && !rx_phase_held && !t.rx_level) begin
                rx_pick       = 3'((int'(phase) + START_DELAY) % OVERSAMPLE_DEF);
                rx_phase_held = 1'b1;
            end
            if (rx_on && rx_pick == phase)
                take_rx_bit(t.rx_level);
            if (phase == 3'd0)
                drive_tx_slot();
            phase = (int'(phase) == OVERSAMPLE_DEF - 1) ? 3'd0 : phase + 3'd1;

            s              = '0;
            s.tx_level     = tx_pin;
            s.tx_busy      = tx_running || (tx_used > 0);
            s.tx_ready     = (tx_used < TX_DEPTH_DEF);
            s.rx_head_byte = (rx_used > 0) ? rx_fifo[0] : 8'h00;
            s.rx_count     = rx_used[3:0];
            status_due.push_back(s);
        endfunction

        function void check_status(status_word_t got);
            status_word_t want;
            if (status_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("status word %04h arrived with none expected", got);
                return;
            end
            want = status_due.pop_front();
            if (got.tx_level !== want.tx_level || got.tx_busy !== want.tx_busy
                    || got.tx_ready !== want.tx_ready
                    || got.rx_head_byte !== want.rx_head_byte
                    || got.rx_count !== want.rx_count) begin
                errors++;
                if (errors <= 10)
                    $display("status mismatch: expected level=%0b busy=%0b ready=%0b",
                             want.tx_level, want.tx_busy, want.tx_ready,
                             " head=%02h count=%0d,", want.rx_head_byte, want.rx_count,
                             " got level=%0b busy=%0b ready=%0b",
                             got.tx_level, got.tx_busy, got.tx_ready,
                             " head=%02h count=%0d", got.rx_head_byte, got.rx_count);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0: rx_level, tx_valid, tx_byte[7:0], rx_pop, zero padding.
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0: tx_level, tx_busy, tx_ready, rx_head_byte[7:0], rx_count[3:0],
    // zero padding.
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    uart_scoreboard sb;
    bit calm;
    bit bursts_on;
    int push_odds;
    int pop_odds;
    int ticks_sent;
    int stall_left;

    oversampled_uart_8n1_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_tick(tick_word_t'(s_tdata));
        if (rst_n && m_tvalid && m_tready)
            sb.check_status(status_word_t'(m_tdata));
    end

    // The receiving side stalls in random bursts until the final stretch.
    initial
    begin
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 15) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic level, input logic push, input logic [7:0] data,
                             input logic pop);
        tick_word_t w;
        int gap;
        w          = '0;
        w.rx_level = level;
        w.tx_valid = push;
        w.tx_byte  = data;
        w.rx_pop   = pop;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic send_line(input logic level);
        logic push;
        logic pop;
        push = (push_odds != 0) && ($urandom_range(1, push_odds) == 1);
        pop  = (pop_odds != 0) && ($urandom_range(1, pop_odds) == 1);
        send_tick(level, push, 8'($urandom_range(0, 255)), pop);
    endtask

    task automatic send_frame(input logic [7:0] data, input logic stop_level);
        logic [9:0] bits;
        bits = {stop_level, data, 1'b0};
        repeat ($urandom_range(0, 6)) send_line(1'b1);
        for (int b = 0; b < 10; b++)
            repeat (OVERSAMPLE_DEF) send_line(bits[b]);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 12)) send_line(1'($urandom_range(0, 1)));
            1:
            begin
                repeat ($urandom_range(1, 2)) send_line(1'b0);
                repeat (8) send_line(1'b1);
            end
            default:
            begin
                repeat (OVERSAMPLE_DEF) send_line(1'b0);
                repeat ($urandom_range(1, 6))
                    repeat (OVERSAMPLE_DEF) send_line(1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic run_until(input int last_tick, input int frame_pct);
        int pick;
        while (ticks_sent < last_tick)
        begin
            pick = $urandom_range(1, 100);
            if (pick <= frame_pct)
                send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 15) != 0);
            else if (bursts_on && pick % 3 == 0)
                repeat ($urandom_range(4, 18))
                    send_tick(1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'b0);
            else
                send_noise();
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic set_rx_enable(input logic enable_bit);
        hold_until_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RX_ENABLE_ADDR;
        pwdata  <= APB_DATA_W'(enable_bit);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_rx_on(enable_bit);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        sb         = new();
        calm       = 1'b0;
        bursts_on  = 1'b0;
        push_odds  = 0;
        pop_odds   = 0;
        ticks_sent = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Receive stays off here, so low levels must not start a frame.
        set_rx_enable(1'b0);
        send_tick(1'b1, 1'b0, 8'h00, 1'b1);
        send_tick(1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(1'b0, 1'b0, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b0);
        send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
        // Fill the transmit queue and push twice more while it is full.
        repeat (TX_DEPTH_DEF - 1)
            send_tick(1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'b0);
        send_tick(1'b0, 1'b1, 8'h5A, 1'b1);

        set_rx_enable(1'b1);
        send_frame(8'h00, 1'b1);
        send_frame(8'hFF, 1'b1);
        send_frame(8'hA5, 1'b0);
        repeat (2) send_line(1'b0);
        repeat (8) send_line(1'b1);
        send_frame(8'h3C, 1'b1);
        run_until(760, 90);

        // Receive is off while the receive queue is drained by pops.
        set_rx_enable(1'b0);
        push_odds = 15;
        pop_odds  = 3;
        run_until(830, 50);

        set_rx_enable(1'b1);
        push_odds = 60;
        pop_odds  = 30;
        bursts_on = 1'b1;
        run_until(960, 75);
        hold_until_drained();
        run_until(990, 75);
        calm = 1'b1;
        run_until(1100, 75);

        hold_until_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
